// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/psch_pkg.sv -----
// ----------------------------------------------------------------------------
// psch_pkg
// Types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psch_pkg;

  localparam int TIME_W  = 21;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TASK_W  = 4;
  localparam int ROW_W   = ARR_W + BURST_W + PRIO_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // input action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_PREP   = 4'b0100,
    ST_COMMIT = 4'b1000
  } psch_state_t;

  typedef struct packed {
    logic load;    // store the presented task
    logic start;   // begin a tick: clear the scan
    logic scan;    // step the task scan
    logic prep;    // read service count, form turnaround
    logic commit;  // update task, load result register, advance time
  } psch_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } psch_sts_t;

endpackage

// ----- src/preemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a table of up to MAX_TASKS tasks.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_action selects a load or a tick.
//   A load stores arrival, burst and priority under the next task number and
//   produces no result; loads past MAX_TASKS are dropped.
//   A tick grants one time unit to the arrived, unfinished task with the
//   smallest priority number (lowest task number on a tie) and produces one
//   result transaction on the output channel.
// Sequence: a tick is accepted, then scanned (one task row read a cycle from
//   the task table RAM, registered read); the service count is then read and
//   the task updated. in_ready returns with the result, so a new tick is not
//   accepted until the previous one has produced its result.
// Output channel (out_valid/out_ready): a result register holds the result, so
//   the next transaction is accepted while it waits. If the receiver stalls,
//   a following tick completes its scan and then waits in its update step.
// Reset (rst_n, synchronous, active low) empties the task table, clears time
//   to zero and drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic [psch_pkg::ARR_W-1:0]   in_arrival_time,
  input  logic [psch_pkg::BURST_W-1:0] in_burst_length,
  input  logic [psch_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psch_pkg::TIME_W-1:0]  out_current_time,
  output logic                         out_grant_valid,
  output logic [psch_pkg::TASK_W-1:0]  out_granted_task,
  output logic                         out_task_completed,
  output logic [psch_pkg::TIME_W-1:0]  out_turnaround_time,
  output logic [psch_pkg::TIME_W-1:0]  out_waiting_time,
  output logic                         out_all_done
);

  import psch_pkg::*;

  psch_cmd_t cmd;
  psch_sts_t sts;

  psch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  psch_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_arrival_time     (in_arrival_time),
    .in_burst_length     (in_burst_length),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_current_time    (out_current_time),
    .out_grant_valid     (out_grant_valid),
    .out_granted_task    (out_granted_task),
    .out_task_completed  (out_task_completed),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_all_done        (out_all_done)
  );

endmodule

// ----- src/psch_ram.sv -----
// ----------------------------------------------------------------------------
// psch_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/psch_ctrl.sv -----
// ----------------------------------------------------------------------------
// psch_ctrl
// Sequencer: accepts transactions and steps the datapath through a tick.
// ----------------------------------------------------------------------------
module psch_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  output psch_pkg::psch_cmd_t cmd,
  input  psch_pkg::psch_sts_t sts
);

  import psch_pkg::*;

  psch_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_TICK) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the new result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/psch_dp.sv -----
// ----------------------------------------------------------------------------
// psch_dp
// Datapath: task tables, priority scan, service accounting, result register.
// ----------------------------------------------------------------------------
module psch_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psch_pkg::psch_cmd_t                 cmd,
  output psch_pkg::psch_sts_t                 sts,
  input  logic [psch_pkg::ARR_W-1:0]          in_arrival_time,
  input  logic [psch_pkg::BURST_W-1:0]        in_burst_length,
  input  logic [psch_pkg::PRIO_W-1:0]         in_priority_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psch_pkg::TIME_W-1:0]         out_current_time,
  output logic                                out_grant_valid,
  output logic [psch_pkg::TASK_W-1:0]         out_granted_task,
  output logic                                out_task_completed,
  output logic [psch_pkg::TIME_W-1:0]         out_turnaround_time,
  output logic [psch_pkg::TIME_W-1:0]         out_waiting_time,
  output logic                                out_all_done
);

  import psch_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

  // control state
  logic [CNT_W-1:0]     task_cnt_r, task_cnt_nxt;
  logic [CNT_W-1:0]     open_cnt_r, open_cnt_nxt;
  logic [MAX_TASKS-1:0] fin_r, fin_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [ARR_W-1:0]     best_arr_r, best_arr_nxt;
  logic [BURST_W-1:0]   best_burst_r, best_burst_nxt;
  logic [PRIO_W-1:0]    best_prio_r, best_prio_nxt;
  logic [TIME_W-1:0]    ta_r, ta_nxt;
  logic [TIME_W-1:0]    o_time_r, o_time_nxt;
  logic                 o_grant_r, o_grant_nxt;
  logic [TASK_W-1:0]    o_task_r, o_task_nxt;
  logic                 o_done_r, o_done_nxt;
  logic [TIME_W-1:0]    o_ta_r, o_ta_nxt;
  logic [TIME_W-1:0]    o_wt_r, o_wt_nxt;
  logic                 o_all_r, o_all_nxt;

  // memories
  logic                 load_ok;
  logic [IDX_W-1:0]     load_addr;
  logic [ROW_W-1:0]     row_q;
  logic                 srv_we;
  logic [IDX_W-1:0]     srv_waddr;
  logic [BURST_W-1:0]   srv_wdata;
  logic [BURST_W-1:0]   srv_q;

  // scan row fields
  logic [ARR_W-1:0]     row_arr;
  logic [BURST_W-1:0]   row_burst;
  logic [PRIO_W-1:0]    row_prio;
  logic                 row_elig;

  // commit arithmetic
  logic [BURST_W-1:0]   burst_eff;
  logic [BURST_W:0]     served_inc;
  logic                 done_now;
  logic [TIME_W:0]      ta_full;
  logic [IDX_W+TASK_W-1:0] idx_ext;

  assign load_ok   = cmd.load && (task_cnt_r < CNT_MAX);
  assign load_addr = task_cnt_r[IDX_W-1:0];

  assign {row_arr, row_burst, row_prio} = row_q;
  assign row_elig = !fin_r[rd_idx_r] && ({(TIME_W-ARR_W)'(0), row_arr} <= time_r);

  psch_ram #(.WIDTH(ROW_W), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_addr),
    .wdata ({in_arrival_time, in_burst_length, in_priority_req}),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (row_q)
  );

  // service counts: cleared on load, bumped on grant
  assign srv_we    = load_ok || (cmd.commit && found_r);
  assign srv_waddr = cmd.commit ? best_idx_r : load_addr;
  assign srv_wdata = cmd.commit ? served_inc[BURST_W-1:0] : '0;

  psch_ram #(.WIDTH(BURST_W), .DEPTH(MAX_TASKS)) u_srv_ram (
    .clk   (clk),
    .we    (srv_we),
    .waddr (srv_waddr),
    .wdata (srv_wdata),
    .raddr (best_idx_r),
    .rdata (srv_q)
  );

  // a zero burst is served as a burst of one
  assign burst_eff  = (best_burst_r == '0) ? BURST_W'(1) : best_burst_r;
  assign served_inc = {1'b0, srv_q} + (BURST_W+1)'(1);
  assign done_now   = found_r && (served_inc >= {1'b0, burst_eff});
  assign ta_full    = {1'b0, time_r} + (TIME_W+1)'(1) - {(TIME_W+1-ARR_W)'(0), best_arr_r};
  assign idx_ext    = {{TASK_W{1'b0}}, best_idx_r};

  always_comb begin
    task_cnt_nxt   = task_cnt_r;
    open_cnt_nxt   = open_cnt_r;
    fin_nxt        = fin_r;
    time_nxt       = time_r;
    scan_idx_nxt   = scan_idx_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_arr_nxt   = best_arr_r;
    best_burst_nxt = best_burst_r;
    best_prio_nxt  = best_prio_r;
    ta_nxt         = ta_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_time_nxt     = o_time_r;
    o_grant_nxt    = o_grant_r;
    o_task_nxt     = o_task_r;
    o_done_nxt     = o_done_r;
    o_ta_nxt       = o_ta_r;
    o_wt_nxt       = o_wt_r;
    o_all_nxt      = o_all_r;

    if (load_ok) begin
      fin_nxt[load_addr] = 1'b0;
      task_cnt_nxt       = task_cnt_r + CNT_W'(1);
      open_cnt_nxt       = open_cnt_r + CNT_W'(1);
    end

    if (cmd.start) begin
      scan_idx_nxt = '0;
      rd_vld_nxt   = 1'b0;
      found_nxt    = 1'b0;
    end

    if (cmd.scan) begin
      // one read issued and one row judged per cycle
      rd_vld_nxt = scan_idx_r < task_cnt_r;
      rd_idx_nxt = scan_idx_r[IDX_W-1:0];
      if (scan_idx_r < task_cnt_r) begin
        scan_idx_nxt = scan_idx_r + CNT_W'(1);
      end
      if (rd_vld_r && row_elig && (!found_r || (row_prio < best_prio_r))) begin
        found_nxt      = 1'b1;
        best_idx_nxt   = rd_idx_r;
        best_arr_nxt   = row_arr;
        best_burst_nxt = row_burst;
        best_prio_nxt  = row_prio;
      end
    end

    if (cmd.prep) begin
      ta_nxt = ta_full[TIME_W] ? TIME_MAX : ta_full[TIME_W-1:0];
    end

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      o_time_nxt    = time_r;
      o_grant_nxt   = found_r;
      o_task_nxt    = found_r ? idx_ext[TASK_W-1:0] : '0;
      o_done_nxt    = done_now;
      o_ta_nxt      = done_now ? ta_r : '0;
      if (done_now && (ta_r >= {(TIME_W-BURST_W)'(0), burst_eff})) begin
        o_wt_nxt = ta_r - {(TIME_W-BURST_W)'(0), burst_eff};
      end else begin
        o_wt_nxt = '0;
      end
      if (done_now) begin
        fin_nxt[best_idx_r] = 1'b1;
      end
      open_cnt_nxt = open_cnt_r - CNT_W'(done_now);
      o_all_nxt    = (open_cnt_nxt == '0);
      if (time_r != TIME_MAX) begin
        time_nxt = time_r + TIME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_cnt_r  <= '0;
      open_cnt_r  <= '0;
      fin_r       <= '0;
      time_r      <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      task_cnt_r  <= task_cnt_nxt;
      open_cnt_r  <= open_cnt_nxt;
      fin_r       <= fin_nxt;
      time_r      <= time_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_arr_r   <= best_arr_nxt;
    best_burst_r <= best_burst_nxt;
    best_prio_r  <= best_prio_nxt;
    ta_r         <= ta_nxt;
    o_time_r     <= o_time_nxt;
    o_grant_r    <= o_grant_nxt;
    o_task_r     <= o_task_nxt;
    o_done_r     <= o_done_nxt;
    o_ta_r       <= o_ta_nxt;
    o_wt_r       <= o_wt_nxt;
    o_all_r      <= o_all_nxt;
  end

  assign sts.scan_done = (scan_idx_r == task_cnt_r) && !rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_current_time    = o_time_r;
  assign out_grant_valid     = o_grant_r;
  assign out_granted_task    = o_task_r;
  assign out_task_completed  = o_done_r;
  assign out_turnaround_time = o_ta_r;
  assign out_waiting_time    = o_wt_r;
  assign out_all_done        = o_all_r;

endmodule

// ----- src/psch_checker.sv -----
// ----------------------------------------------------------------------------
// psch_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psch_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [psch_pkg::TIME_W-1:0]  out_current_time,
  input logic                         out_grant_valid,
  input logic [psch_pkg::TASK_W-1:0]  out_granted_task,
  input logic                         out_task_completed,
  input logic [psch_pkg::TIME_W-1:0]  out_turnaround_time,
  input logic [psch_pkg::TIME_W-1:0]  out_waiting_time,
  input logic                         out_all_done
);

  // a stalled result transaction keeps its place and its time stamp
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_current_time), "result dropped or changed while stalled")

  // completion only comes with a grant and a non-zero turnaround
  `ASSERT_CLK(a_done_grant, clk, rst_n, out_valid && out_task_completed |-> out_grant_valid && (out_turnaround_time != '0), "completion without grant")

  // without a grant every task field reads zero
  `ASSERT_CLK(a_idle_zero, clk, rst_n, out_valid && !out_grant_valid |-> (out_granted_task == '0) && !out_task_completed && (out_waiting_time == '0), "idle tick carries task data")

  `ASSERT_CLK(a_wait_le_ta, clk, rst_n, out_valid |-> out_waiting_time <= out_turnaround_time, "waiting time exceeds turnaround")

  // reset leaves no result pending and the input open
  `ASSERT_CLK_ALWAYS(a_reset, clk, !rst_n |=> !out_valid && in_ready, "state after reset")

endmodule

bind preemptive_priority_scheduler psch_checker u_psch_checker (.*);
